FILE: rtl/core/password_entropy_check_assert.svh
// ============================================================================
// Assertion macros for the password entropy checker
// Concurrent checks on the rising clock edge, disabled while reset is high.
// They compile to nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef PASSWORD_ENTROPY_CHECK_ASSERT_SVH
`define PASSWORD_ENTROPY_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication: prop is a full property expression
`define PEC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// cond in one cycle implies nxt in the following cycle
`define PEC_ASSERT_NEXT(lbl, cond, nxt, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);
`else
`define PEC_ASSERT(lbl, prop, msg)
`define PEC_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif
`endif

FILE: rtl/core/pec_pkg.sv
// ============================================================================
// pec_pkg
// Widths, word types, register indexes and the entropy term table of the
// password entropy checker.
// ============================================================================
package pec_pkg;

   // sizes
   localparam int unsigned MAX_LEN    = 1024;
   localparam int unsigned FRAC_BITS  = 8;
   localparam int unsigned SYM_W      = 8;
   localparam int unsigned HIST_DEPTH = 256;
   localparam int unsigned LEN_W      = 11;
   localparam int unsigned TERM_W     = 22;
   localparam int unsigned ACC_W      = TERM_W + 1;
   localparam int unsigned ROM_AW     = $clog2(MAX_LEN);
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 22;
   localparam int unsigned RSP_DEPTH_DEFAULT = 8;

   // register reset values
   localparam logic [LEN_W-1:0]  MIN_LENGTH_RESET  = LEN_W'(20);
   localparam logic [TERM_W-1:0] MIN_ENTROPY_RESET = TERM_W'(20480);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ENTROPY = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      VERDICT_OK          = 2'd0,
      VERDICT_SHORT       = 2'd1,
      VERDICT_LOW_ENTROPY = 2'd2,
      VERDICT_TOO_LONG    = 2'd3
   } verdict_type;

   // channel words
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [TERM_W-1:0] entropy_q8;
      logic [LEN_W-1:0]  length;
      verdict_type       verdict;
   } rsp_type;

   // one byte travelling down the pipe
   typedef struct packed {
      logic              valid;
      logic              last;
      logic              counted;   // byte fits under the length limit
      logic [SYM_W-1:0]  symbol;
      logic [ROM_AW-1:0] len_idx;   // byte count before this byte
      logic [LEN_W-1:0]  len;       // byte count after this byte
      logic              ovl;       // password ran past the limit
   } item_type;

   typedef struct packed {
      logic [LEN_W-1:0]  min_length;
      logic [TERM_W-1:0] min_entropy;
   } cfg_type;

   // last words still inside the accumulator stages
   typedef struct packed {
      logic s2_last;
      logic s3_last;
   } pipe_status_type;

   // log2(n), 32 fraction bits, by repeated squaring of the mantissa
   function automatic logic [63:0] log2_q32(input logic [63:0] n);
      logic [63:0] y;
      logic [63:0] frac;
      int unsigned k;
      int          b;
      int          i;
      k = 0;
      for (b = 0; b < 63; b++) begin
         if ((n >> (b + 1)) != 64'd0) k = b + 1;
      end
      y    = (n << 31) >> k;
      frac = 64'd0;
      for (i = 1; i <= 32; i++) begin
         y = (y * y) >> 31;
         if (y >= 64'h1_0000_0000) begin
            y    = y >> 1;
            frac = frac | (64'd1 << (32 - i));
         end
      end
      return (64'(k) << 32) | frac;
   endfunction

   // D(c) = T(c+1) - T(c), T(n) = round(n * log2(n) * 2^FRAC_BITS)
   typedef logic [TERM_W-1:0] term_rom_type [MAX_LEN];

   function automatic term_rom_type build_delta();
      term_rom_type rom;
      logic [63:0]  t_prev;
      logic [63:0]  t_cur;
      logic [63:0]  p;
      int           n;
      t_prev = 64'd0;
      for (n = 1; n <= MAX_LEN; n++) begin
         p      = 64'(n) * log2_q32(64'(n));
         t_cur  = (p + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
         rom[n - 1] = TERM_W'(t_cur - t_prev);
         t_prev = t_cur;
      end
      return rom;
   endfunction

   localparam term_rom_type DELTA_ROM = build_delta();

endpackage

FILE: rtl/core/pec_hist.sv
// ============================================================================
// pec_hist
// Byte histogram: 256 counts in a synchronous memory, read-modify-write with
// one write-forward register, valid bits cleared at the end of a password.
// ============================================================================
`include "password_entropy_check_assert.svh"

module pec_hist import pec_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  item_type          in_item,    // byte at the accept edge
   output item_type          s1_item,    // same byte in the next cycle
   output logic [ROM_AW-1:0] cnt_idx     // bin count before this byte
);

   logic [LEN_W-1:0]      count_mem [HIST_DEPTH];
   logic [LEN_W-1:0]      rd_data_ff;
   logic [HIST_DEPTH-1:0] vbit_ff, vbit_in;
   item_type              s1_ff, s1_in;
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [SYM_W-1:0]      fwd_addr_ff, fwd_addr_in;
   logic [LEN_W-1:0]      fwd_data_ff, fwd_data_in;
   logic [LEN_W-1:0]      cnt, cnt_inc;
   logic                  write_en;

   assign s1_in = in_item;

   // current count: last write, else memory if the bin was touched
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_ff.symbol)) begin
         cnt = fwd_data_ff;
      end else if (vbit_ff[s1_ff.symbol]) begin
         cnt = rd_data_ff;
      end else begin
         cnt = '0;
      end
      cnt_inc = cnt + LEN_W'(1);
   end

   // write back only within a password; the last byte clears every bin
   always_comb begin
      write_en     = s1_ff.valid && s1_ff.counted && !s1_ff.last;
      fwd_valid_in = write_en;
      fwd_addr_in  = s1_ff.symbol;
      fwd_data_in  = cnt_inc;
      vbit_in      = vbit_ff;
      if (s1_ff.valid && s1_ff.last) begin
         vbit_in = '0;
      end else if (write_en) begin
         vbit_in[s1_ff.symbol] = 1'b1;
      end
   end

   // count memory
   always_ff @(posedge clock) begin
      if (write_en) begin
         count_mem[s1_ff.symbol] <= cnt_inc;
      end
      rd_data_ff <= count_mem[in_item.symbol];
   end

   // control and forward registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         vbit_ff      <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         vbit_ff      <= vbit_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   assign s1_item = s1_ff;
   // counted bytes never reach a bin count of MAX_LEN
   assign cnt_idx = cnt[ROM_AW-1:0];

   `PEC_ASSERT_NEXT(a_hist_clear, s1_ff.valid && s1_ff.last, vbit_ff == '0,
      "histogram not cleared after last word")

endmodule

FILE: rtl/core/pec_term_rom.sv
// ============================================================================
// pec_term_rom
// Entropy term increment table, two registered read ports.
// ============================================================================
module pec_term_rom import pec_pkg::*; (
   input  logic              clock,
   input  logic [ROM_AW-1:0] addr_a,
   input  logic [ROM_AW-1:0] addr_b,
   output logic [TERM_W-1:0] data_a,
   output logic [TERM_W-1:0] data_b
);

   logic [TERM_W-1:0] data_a_ff, data_b_ff;

   // registered reads
   always_ff @(posedge clock) begin
      data_a_ff <= DELTA_ROM[addr_a];
      data_b_ff <= DELTA_ROM[addr_b];
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

FILE: rtl/core/pec_accum.sv
// ============================================================================
// pec_accum
// Running term sums per password, then entropy and verdict for the last word.
// ============================================================================
module pec_accum import pec_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  item_type          s1_item,
   input  logic [TERM_W-1:0] cnt_term,   // D(bin count), aligned with stage 2
   input  logic [TERM_W-1:0] len_term,   // D(byte count), aligned with stage 2
   input  cfg_type           cfg,
   output logic              push,
   output rsp_type           push_word,
   output pipe_status_type   status
);

   typedef struct packed {
      logic             valid;
      logic             ovl;
      logic [LEN_W-1:0] len;
      logic [ACC_W-1:0] full;
      logic [ACC_W-1:0] sum;
   } result_stage_type;

   item_type          s2_ff, s2_in;
   logic [ACC_W-1:0]  sum_ff, sum_in, full_ff, full_in;
   logic [ACC_W-1:0]  sum_next, full_next;
   result_stage_type  s3_ff, s3_in;
   logic [ACC_W-1:0]  diff;
   logic [TERM_W-1:0] ent;
   verdict_type       verdict;

   assign s2_in = s1_item;

   // stage 2: add the increments, restart at zero after the last word
   always_comb begin
      sum_next  = sum_ff  + (s2_ff.counted ? ACC_W'(cnt_term) : '0);
      full_next = full_ff + (s2_ff.counted ? ACC_W'(len_term) : '0);
      sum_in    = sum_ff;
      full_in   = full_ff;
      if (s2_ff.valid) begin
         if (s2_ff.last) begin
            sum_in  = '0;
            full_in = '0;
         end else begin
            sum_in  = sum_next;
            full_in = full_next;
         end
      end
      s3_in.valid = s2_ff.valid && s2_ff.last;
      s3_in.ovl   = s2_ff.ovl;
      s3_in.len   = s2_ff.len;
      s3_in.full  = full_next;
      s3_in.sum   = sum_next;
   end

   // stage 3: entropy, clamped at zero, and verdict
   always_comb begin
      diff = s3_ff.full - s3_ff.sum;
      ent  = (s3_ff.full >= s3_ff.sum) ? diff[TERM_W-1:0] : '0;
      if (s3_ff.ovl) begin
         verdict = VERDICT_TOO_LONG;
      end else if (s3_ff.len < cfg.min_length) begin
         verdict = VERDICT_SHORT;
      end else if (ent < cfg.min_entropy) begin
         verdict = VERDICT_LOW_ENTROPY;
      end else begin
         verdict = VERDICT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff   <= '0;
         s3_ff   <= '0;
         sum_ff  <= '0;
         full_ff <= '0;
      end else begin
         s2_ff   <= s2_in;
         s3_ff   <= s3_in;
         sum_ff  <= sum_in;
         full_ff <= full_in;
      end
   end

   assign push                 = s3_ff.valid;
   assign push_word.entropy_q8 = ent;
   assign push_word.length     = s3_ff.len;
   assign push_word.verdict    = verdict;
   assign status.s2_last       = s2_ff.valid && s2_ff.last;
   assign status.s3_last       = s3_ff.valid;

endmodule

FILE: rtl/core/pec_rsp_fifo.sv
// ============================================================================
// pec_rsp_fifo
// Small response queue in registers, word shown from the head entry.
// ============================================================================
`include "password_entropy_check_assert.svh"

module pec_rsp_fifo import pec_pkg::*; #(
   parameter int unsigned DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rsp_type                    push_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_word,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rsp_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop = rsp_valid && rsp_ready;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   `PEC_ASSERT(a_fifo_room, push |-> ((count_ff < DEPTH) || pop),
      "response word pushed into a full queue")

endmodule

FILE: rtl/core/password_entropy_check.sv
// ============================================================================
// password_entropy_check
// Shannon entropy of a password from a byte histogram, with length and
// entropy limits giving a pass or fail verdict on the last byte.
// ============================================================================
//
//  channel  dir  handshake              word
//  req      in   req_valid/req_ready    req_word: symbol, last
//  rsp      out  rsp_valid/rsp_ready    rsp_word: entropy_q8, length, verdict
//  csr      in   csr_valid/csr_ready    csr_index, csr_wdata (ready tied high)
//
//  One byte per cycle while req_ready is high. After the edge that accepts
//  its last byte, a result word passes through the histogram read with
//  count update, table lookup and sum, then entropy and verdict into the
//  response queue, which drives rsp_valid. The histogram read-modify-write
//  closes through a write-forward register. req_ready drops only when queued
//  plus in-flight result words would fill the RSP_DEPTH response queue.
//  Reset clears all histogram valid bits at once; there is no sweep.
// ============================================================================
`include "password_entropy_check_assert.svh"

module password_entropy_check import pec_pkg::*; #(
   parameter int unsigned RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned FIFO_CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int unsigned RES_W      = $clog2(RSP_DEPTH + 4);

   logic                  accept, counted;
   logic [LEN_W-1:0]      byte_total_ff, byte_total_in;
   logic                  ovl_ff, ovl_in;
   logic [LEN_W-1:0]      min_length_ff, min_length_in;
   logic [TERM_W-1:0]     min_entropy_ff, min_entropy_in;
   item_type              in_item, s1_item;
   logic [ROM_AW-1:0]     cnt_idx;
   logic [TERM_W-1:0]     cnt_term, len_term;
   cfg_type               cfg;
   logic                  push;
   rsp_type               push_word;
   pipe_status_type       status;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [RES_W-1:0]      reserved;

   // result slots taken by queued and in-flight last words
   assign reserved = RES_W'(fifo_count) + RES_W'(s1_item.valid && s1_item.last)
                   + RES_W'(status.s2_last) + RES_W'(status.s3_last);
   assign req_ready = (reserved < RES_W'(RSP_DEPTH));
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // byte counter and overlength flag at the accept edge
   always_comb begin
      counted          = (byte_total_ff < LEN_W'(MAX_LEN));
      in_item.valid    = accept;
      in_item.last     = req_word.last;
      in_item.counted  = counted;
      in_item.symbol   = req_word.symbol;
      in_item.len_idx  = byte_total_ff[ROM_AW-1:0];
      in_item.len      = counted ? byte_total_ff + LEN_W'(1) : byte_total_ff;
      in_item.ovl      = ovl_ff || !counted;
      byte_total_in    = byte_total_ff;
      ovl_in           = ovl_ff;
      if (accept) begin
         byte_total_in = req_word.last ? '0 : in_item.len;
         ovl_in        = !req_word.last && in_item.ovl;
      end
   end

   // register writes
   always_comb begin
      min_length_in  = min_length_ff;
      min_entropy_in = min_entropy_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_LENGTH:  min_length_in  = csr_wdata[LEN_W-1:0];
            CSR_MIN_ENTROPY: min_entropy_in = csr_wdata[TERM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_total_ff  <= '0;
         ovl_ff         <= 1'b0;
         min_length_ff  <= MIN_LENGTH_RESET;
         min_entropy_ff <= MIN_ENTROPY_RESET;
      end else begin
         byte_total_ff  <= byte_total_in;
         ovl_ff         <= ovl_in;
         min_length_ff  <= min_length_in;
         min_entropy_ff <= min_entropy_in;
      end
   end

   assign cfg.min_length  = min_length_ff;
   assign cfg.min_entropy = min_entropy_ff;

   pec_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .in_item (in_item),
      .s1_item (s1_item),
      .cnt_idx (cnt_idx)
   );

   pec_term_rom u_term_rom (
      .clock  (clock),
      .addr_a (cnt_idx),
      .addr_b (s1_item.len_idx),
      .data_a (cnt_term),
      .data_b (len_term)
   );

   pec_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .s1_item   (s1_item),
      .cnt_term  (cnt_term),
      .len_term  (len_term),
      .cfg       (cfg),
      .push      (push),
      .push_word (push_word),
      .status    (status)
   );

   pec_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .count     (fifo_count)
   );

   `PEC_ASSERT(a_len_limit, byte_total_ff <= LEN_W'(MAX_LEN),
      "byte counter beyond the length limit")
   `PEC_ASSERT(a_credit, reserved <= RES_W'(RSP_DEPTH),
      "more result words in flight than queue slots")
   `PEC_ASSERT_NEXT(a_restart, accept && req_word.last, byte_total_ff == '0 && !ovl_ff,
      "password state not cleared after last word")

endmodule
